// ===== design/wfrt_pkg.sv =====
// Package for the WebSocket fragment reassembly tracker.
// Holds sizes, codes and the item, state and result structs; depends on nothing.
`default_nettype none

package wfrt_pkg;

  localparam int STAGING_BUFFERS = 2;
  localparam int BUF_W   = 1;
  localparam int FIELD_W = 20;
  localparam int LEN_W   = 17;
  localparam int OFS_W   = 16;
  localparam int GEN_W   = 32;
  localparam int CNT_W   = 32;

  localparam logic [LEN_W-1:0] PAYLOAD_LIMIT = 17'd65536;

  // Item operations.
  localparam logic [1:0] OP_FRAGMENT = 2'd0;
  localparam logic [1:0] OP_RELEASE  = 2'd1;
  localparam logic [1:0] OP_RESET    = 2'd2;

  // Frame opcode low nibble.
  localparam logic [3:0] OPC_CONT   = 4'h0;
  localparam logic [3:0] OPC_TEXT   = 4'h1;
  localparam logic [3:0] OPC_BINARY = 4'h2;
  localparam logic [3:0] OPC_CLOSE  = 4'h8;
  localparam logic [3:0] OPC_PING   = 4'h9;
  localparam logic [3:0] OPC_PONG   = 4'hA;

  typedef enum logic [3:0] {
    ST_IGNORED    = 4'd0,
    ST_STARTED    = 4'd1,
    ST_APPENDED   = 4'd2,
    ST_COMPLETED  = 4'd3,
    ST_DROPPED    = 4'd4,
    ST_DISCARDED  = 4'd5,
    ST_FRAG_ERROR = 4'd6,
    ST_RELEASED   = 4'd7,
    ST_RESET      = 4'd8
  } status_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [7:0]         frame_opcode;
    logic [FIELD_W-1:0] total_length;
    logic [FIELD_W-1:0] fragment_offset;
    logic [FIELD_W-1:0] chunk_length;
    logic [GEN_W-1:0]   conn_generation;
    logic [BUF_W-1:0]   release_index;
  } item_t;

  typedef struct packed {
    logic                       assembling_active;
    logic [BUF_W-1:0]           assembly_buffer;
    logic [LEN_W-1:0]           expected_length;
    logic [LEN_W-1:0]           received_length;
    logic                       first_is_binary;
    logic [GEN_W-1:0]           start_generation;
    logic                       discard_active;
    logic [LEN_W-1:0]           discard_expected;
    logic [LEN_W-1:0]           discard_received;
    logic [STAGING_BUFFERS-1:0] free_buffers;
    logic [CNT_W-1:0]           drops;
    logic [CNT_W-1:0]           fragment_errors;
  } state_t;

  typedef struct packed {
    status_t          status;
    logic [BUF_W-1:0] buffer_index;
    logic [OFS_W-1:0] write_offset;
    logic [LEN_W-1:0] message_length;
    logic [GEN_W-1:0] message_generation;
    logic             message_is_binary;
    logic [CNT_W-1:0] drop_count;
    logic [CNT_W-1:0] fragment_error_count;
  } result_t;

endpackage

`default_nettype wire

// ===== design/websocket_fragment_reassembly_tracker_top.sv =====
// Top level of the WebSocket fragment reassembly tracker: request and result
// registers, tracker state and the limit register; depends on wfrt_pkg and wfrt_step.
`default_nettype none

// The tracker takes one request per clock while out_ready is high and returns
// exactly one result per request, in order. A request passes through an input
// register, is evaluated against the tracker state by combinational compares
// and adds, and moves into the result register as soon as that register is
// empty or being emptied; the sustained rate is one request per cycle while
// the consumer keeps out_ready high.
// The result register releases its slot in the same cycle it is taken, so a
// full pipeline keeps moving whenever out_ready is high; when the consumer
// stalls, the input register still holds one more request before in_ready
// drops. The max_payload register is written with cfg_write_en and should be
// changed only while no request is in flight. Reset clears the tracker state
// with no clearing pass: both staging buffers free, counters zero, and the
// limit back to 65536 bytes. Payload bytes are not moved here; the results
// carry placement (buffer and write offset) and completion details.
module websocket_fragment_reassembly_tracker_top
  import wfrt_pkg::*;
(
  input  wire                      clk,
  input  wire                      rst,

  input  wire                      cfg_write_en,
  input  wire  [LEN_W-1:0]         cfg_write_data,

  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire  [1:0]               op,
  input  wire  [7:0]               frame_opcode,
  input  wire  [FIELD_W-1:0]       total_length,
  input  wire  [FIELD_W-1:0]       fragment_offset,
  input  wire  [FIELD_W-1:0]       chunk_length,
  input  wire  [GEN_W-1:0]         conn_generation,
  input  wire  [BUF_W-1:0]         release_index,

  output logic                     out_valid,
  input  wire                      out_ready,
  output logic [3:0]               status,
  output logic [BUF_W-1:0]         buffer_index,
  output logic [OFS_W-1:0]         write_offset,
  output logic [LEN_W-1:0]         message_length,
  output logic [GEN_W-1:0]         message_generation,
  output logic                     message_is_binary,
  output logic [CNT_W-1:0]         drop_count,
  output logic [CNT_W-1:0]         fragment_error_count
);

  logic [LEN_W-1:0] max_payload;
  state_t           st;
  state_t           st_next;
  state_t           st_init;
  item_t            req;
  logic             req_valid;
  result_t          res_next;
  result_t          res;
  logic             advance;

  // The evaluation stage moves whenever the result register is empty or is
  // being emptied this cycle.
  assign advance  = !out_valid || out_ready;
  assign in_ready = !req_valid || advance;

  // Reset image of the tracker state: everything zero, every buffer free.
  always_comb begin
    st_init              = '0;
    st_init.free_buffers = '1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= PAYLOAD_LIMIT;
    end else if (cfg_write_en) begin
      max_payload <= cfg_write_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req.op              <= op;
      req.frame_opcode    <= frame_opcode;
      req.total_length    <= total_length;
      req.fragment_offset <= fragment_offset;
      req.chunk_length    <= chunk_length;
      req.conn_generation <= conn_generation;
      req.release_index   <= release_index;
    end
  end

  wfrt_step u_step (
    .st          (st),
    .item        (req),
    .max_payload (max_payload),
    .st_next     (st_next),
    .res         (res_next)
  );

  // Tracker state commits only when the request moves into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= st_init;
    end else if (advance && req_valid) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && req_valid) begin
      res <= res_next;
    end
  end

  assign status               = res.status;
  assign buffer_index         = res.buffer_index;
  assign write_offset         = res.write_offset;
  assign message_length       = res.message_length;
  assign message_generation   = res.message_generation;
  assign message_is_binary    = res.message_is_binary;
  assign drop_count           = res.drop_count;
  assign fragment_error_count = res.fragment_error_count;

`ifndef ASSERT_OFF
  // The buffer under assembly must never be offered as free.
  a_active_buffer_taken: assert property (@(posedge clk) disable iff (rst)
    st.assembling_active |-> !st.free_buffers[st.assembly_buffer])
    else $error("assembling buffer is marked free");

  // Assembling and discarding exclude each other.
  a_assemble_xor_discard: assert property (@(posedge clk) disable iff (rst)
    !(st.assembling_active && st.discard_active))
    else $error("assembly and discard active together");

  // An open assembly has always received less than its total.
  a_recv_below_total: assert property (@(posedge clk) disable iff (rst)
    st.assembling_active |-> (st.received_length < st.expected_length))
    else $error("open assembly has reached its total");

  // Counters change only when a request commits.
  a_error_count_step: assert property (@(posedge clk) disable iff (rst)
    !(advance && req_valid) |=> $stable(st.fragment_errors) && $stable(st.drops))
    else $error("counter changed without a committed request");

  // A completed result always describes a message of nonzero length.
  a_complete_length: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.status == ST_COMPLETED) |-> (res.message_length != '0))
    else $error("completed message with zero length");
`endif

endmodule

`default_nettype wire

// ===== design/wfrt_step.sv =====
// Next-state and result logic of the reassembly tracker for one request.
// Purely combinational; depends on wfrt_pkg.
`default_nettype none

module wfrt_step
  import wfrt_pkg::*;
(
  input  wire state_t           st,
  input  wire item_t            item,
  input  wire logic [LEN_W-1:0] max_payload,
  output state_t                st_next,
  output result_t               res
);

  // Abort returns the assembling buffer and clears all assembly and discard state.
  function automatic state_t abort_state(input state_t s_in);
    state_t s_out;
    s_out = s_in;
    if (s_in.assembling_active) begin
      s_out.free_buffers[s_in.assembly_buffer] = 1'b1;
    end
    s_out.assembling_active = 1'b0;
    s_out.assembly_buffer   = '0;
    s_out.expected_length   = '0;
    s_out.received_length   = '0;
    s_out.first_is_binary   = 1'b0;
    s_out.start_generation  = '0;
    s_out.discard_active    = 1'b0;
    s_out.discard_expected  = '0;
    s_out.discard_received  = '0;
    return s_out;
  endfunction

  always_comb begin
    state_t             s;
    result_t            r;
    logic [3:0]         opc;
    logic [LEN_W-1:0]   limit;
    logic [FIELD_W-1:0] total;
    logic [FIELD_W-1:0] offs;
    logic [FIELD_W-1:0] chunk;
    logic               write;
    logic               found;
    logic               match;
    logic [BUF_W-1:0]   idx;
    logic [LEN_W-1:0]   disc_sum;
    logic [LEN_W-1:0]   recv_sum;

    s        = st;
    r        = '0;
    r.status = ST_IGNORED;
    opc      = item.frame_opcode[3:0];
    limit    = (max_payload > PAYLOAD_LIMIT) ? PAYLOAD_LIMIT : max_payload;
    total    = item.total_length;
    offs     = item.fragment_offset;
    chunk    = item.chunk_length;
    write    = 1'b0;
    found    = 1'b0;
    match    = 1'b0;
    idx      = '0;
    disc_sum = '0;
    recv_sum = '0;

    unique case (item.op)
      OP_RELEASE: begin
        if (!(s.assembling_active && s.assembly_buffer == item.release_index)) begin
          s.free_buffers[item.release_index] = 1'b1;
          r.status       = ST_RELEASED;
          r.buffer_index = item.release_index;
        end
      end
      OP_RESET: begin
        s        = abort_state(s);
        r.status = ST_RESET;
      end
      OP_FRAGMENT: begin
        if (chunk != '0 && total != '0) begin
          // Past the bound checks all lengths fit in LEN_W bits.
          priority if (total > FIELD_W'(limit) || offs > total || chunk > total - offs) begin
            s                 = abort_state(s);
            s.fragment_errors = s.fragment_errors + 32'd1;
            r.status          = ST_FRAG_ERROR;
          end else if (opc == OPC_CLOSE || opc == OPC_PING || opc == OPC_PONG) begin
            r.status = ST_IGNORED;
          end else if (opc > OPC_BINARY) begin
            s                 = abort_state(s);
            s.fragment_errors = s.fragment_errors + 32'd1;
            r.status          = ST_FRAG_ERROR;
          end else if (offs == '0) begin
            s = abort_state(s);
            if (opc == OPC_CONT) begin
              s.fragment_errors = s.fragment_errors + 32'd1;
              r.status          = ST_FRAG_ERROR;
            end else begin
              // Scan from the top so the lowest free buffer wins.
              for (int i = STAGING_BUFFERS - 1; i >= 0; i--) begin
                if (s.free_buffers[i]) begin
                  found = 1'b1;
                  idx   = BUF_W'(i);
                end
              end
              if (!found) begin
                s.drops            = s.drops + 32'd1;
                s.discard_active   = 1'b1;
                s.discard_expected = total[LEN_W-1:0];
                s.discard_received = '0;
                r.status           = ST_DROPPED;
              end else begin
                s.free_buffers[idx] = 1'b0;
                s.assembling_active = 1'b1;
                s.assembly_buffer   = idx;
                s.expected_length   = total[LEN_W-1:0];
                s.received_length   = '0;
                s.first_is_binary   = (opc == OPC_BINARY);
                s.start_generation  = item.conn_generation;
                r.status            = ST_STARTED;
                write               = 1'b1;
              end
            end
          end else if (s.discard_active) begin
            if (FIELD_W'(s.discard_expected) == total &&
                FIELD_W'(s.discard_received) == offs) begin
              disc_sum = LEN_W'(s.discard_received + chunk[LEN_W-1:0]);
              if (disc_sum >= s.discard_expected) begin
                s.discard_active   = 1'b0;
                s.discard_expected = '0;
                s.discard_received = '0;
              end else begin
                s.discard_received = disc_sum;
              end
            end
            r.status = ST_DISCARDED;
          end else begin
            match = (opc == OPC_CONT) || ((opc == OPC_BINARY) == s.first_is_binary);
            if (!s.assembling_active || FIELD_W'(s.expected_length) != total ||
                FIELD_W'(s.received_length) != offs || !match) begin
              s.fragment_errors = s.fragment_errors + 32'd1;
              s                 = abort_state(s);
              r.status          = ST_FRAG_ERROR;
            end else begin
              r.status = ST_APPENDED;
              write    = 1'b1;
            end
          end
        end
      end
      default: begin
        r.status = ST_IGNORED;
      end
    endcase

    if (write) begin
      r.buffer_index    = s.assembly_buffer;
      r.write_offset    = offs[OFS_W-1:0];
      recv_sum          = LEN_W'(offs[LEN_W-1:0] + chunk[LEN_W-1:0]);
      s.received_length = recv_sum;
      if (recv_sum == s.expected_length) begin
        r.status             = ST_COMPLETED;
        r.message_length     = s.expected_length;
        r.message_generation = s.start_generation;
        r.message_is_binary  = s.first_is_binary;
        s.assembling_active  = 1'b0;
        s.assembly_buffer    = '0;
        s.expected_length    = '0;
        s.received_length    = '0;
        s.first_is_binary    = 1'b0;
        s.start_generation   = '0;
      end
    end

    r.drop_count           = s.drops;
    r.fragment_error_count = s.fragment_errors;

    st_next = s;
    res     = r;
  end

endmodule

`default_nettype wire

// ===== dv/websocket_fragment_reassembly_tracker_checker.sv =====
// Result checker for the WebSocket fragment reassembly tracker testbench.
// Watches the request, result and limit ports, predicts every result and
// compares it field by field; depends on wfrt_pkg.
module websocket_fragment_reassembly_tracker_checker
  import wfrt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_en,
  input  logic [LEN_W-1:0]   cfg_write_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         op,
  input  logic [7:0]         frame_opcode,
  input  logic [FIELD_W-1:0] total_length,
  input  logic [FIELD_W-1:0] fragment_offset,
  input  logic [FIELD_W-1:0] chunk_length,
  input  logic [GEN_W-1:0]   conn_generation,
  input  logic [BUF_W-1:0]   release_index,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [3:0]         status,
  input  logic [BUF_W-1:0]   buffer_index,
  input  logic [OFS_W-1:0]   write_offset,
  input  logic [LEN_W-1:0]   message_length,
  input  logic [GEN_W-1:0]   message_generation,
  input  logic               message_is_binary,
  input  logic [CNT_W-1:0]   drop_count,
  input  logic [CNT_W-1:0]   fragment_error_count,
  output int                 mismatch_count,
  output int                 outstanding
);

  logic [LEN_W-1:0]           limit_reg;
  logic                       assembling;
  logic [BUF_W-1:0]           asm_buf;
  logic [LEN_W-1:0]           asm_total;
  logic [LEN_W-1:0]           asm_filled;
  logic                       asm_binary;
  logic [GEN_W-1:0]           asm_gen;
  logic                       discarding;
  logic [LEN_W-1:0]           discard_total;
  logic [LEN_W-1:0]           discard_seen;
  logic [STAGING_BUFFERS-1:0] free_pool;
  logic [CNT_W-1:0]           drop_tally;
  logic [CNT_W-1:0]           error_tally;
  result_t                    expected_results[$];
  int                         mismatches = 0;

  // Aborting a message hands its buffer back and also ends any discard.
  function automatic void abandon_message();
    if (assembling) free_pool[asm_buf] = 1'b1;
    assembling    = 1'b0;
    asm_buf       = '0;
    asm_total     = '0;
    asm_filled    = '0;
    asm_binary    = 1'b0;
    asm_gen       = '0;
    discarding    = 1'b0;
    discard_total = '0;
    discard_seen  = '0;
  endfunction

  function automatic result_t track_request(input logic [1:0] rop, input logic [7:0] ropc,
                                            input logic [FIELD_W-1:0] tot, ofs, chk,
                                            input logic [GEN_W-1:0] gen,
                                            input logic [BUF_W-1:0] rel);
    logic [3:0]       nib;
    logic [LEN_W-1:0] cap;
    logic             place;
    logic             same_kind;
    int               slot;
    result_t          r;
    nib   = ropc[3:0];
    cap   = (limit_reg > PAYLOAD_LIMIT) ? PAYLOAD_LIMIT : limit_reg;
    place = 1'b0;
    slot  = -1;
    r     = '0;
    if (rop == OP_RELEASE) begin
      if (assembling && asm_buf == rel) begin
        r.status = ST_IGNORED;
      end else begin
        free_pool[rel] = 1'b1;
        r.status       = ST_RELEASED;
        r.buffer_index = rel;
      end
    end else if (rop == OP_RESET) begin
      abandon_message();
      r.status = ST_RESET;
    end else if (rop == OP_FRAGMENT && chk != 0 && tot != 0) begin
      // The bounds check wins over every opcode check.
      if (tot > cap || ofs > tot || chk > tot - ofs) begin
        abandon_message();
        error_tally++;
        r.status = ST_FRAG_ERROR;
      end else if (nib == OPC_CLOSE || nib == OPC_PING || nib == OPC_PONG) begin
        r.status = ST_IGNORED;
      end else if (nib > OPC_BINARY) begin
        abandon_message();
        error_tally++;
        r.status = ST_FRAG_ERROR;
      end else if (ofs == 0) begin
        abandon_message();
        if (nib == OPC_CONT) begin
          error_tally++;
          r.status = ST_FRAG_ERROR;
        end else begin
          for (int i = STAGING_BUFFERS - 1; i >= 0; i--) begin
            if (free_pool[i]) slot = i;
          end
          if (slot < 0) begin
            drop_tally++;
            discarding    = 1'b1;
            discard_total = tot[LEN_W-1:0];
            discard_seen  = '0;
            r.status      = ST_DROPPED;
          end else begin
            free_pool[slot] = 1'b0;
            assembling      = 1'b1;
            asm_buf         = slot[BUF_W-1:0];
            asm_total       = tot[LEN_W-1:0];
            asm_filled      = '0;
            asm_binary      = (nib == OPC_BINARY);
            asm_gen         = gen;
            r.status        = ST_STARTED;
            place           = 1'b1;
          end
        end
      end else if (discarding) begin
        if (tot == discard_total && ofs == discard_seen) begin
          discard_seen = discard_seen + chk[LEN_W-1:0];
          if (discard_seen >= discard_total) begin
            discarding    = 1'b0;
            discard_total = '0;
            discard_seen  = '0;
          end
        end
        r.status = ST_DISCARDED;
      end else begin
        same_kind = (nib == OPC_CONT) || ((nib == OPC_BINARY) == asm_binary);
        if (!assembling || asm_total != tot || ofs != asm_filled || !same_kind) begin
          error_tally++;
          abandon_message();
          r.status = ST_FRAG_ERROR;
        end else begin
          r.status = ST_APPENDED;
          place    = 1'b1;
        end
      end
    end
    if (place) begin
      r.buffer_index = asm_buf;
      r.write_offset = ofs[OFS_W-1:0];
      asm_filled     = ofs[LEN_W-1:0] + chk[LEN_W-1:0];
      if (asm_filled == asm_total) begin
        r.status             = ST_COMPLETED;
        r.message_length     = asm_total;
        r.message_generation = asm_gen;
        r.message_is_binary  = asm_binary;
        assembling           = 1'b0;
        asm_buf              = '0;
        asm_total            = '0;
        asm_filled           = '0;
        asm_binary           = 1'b0;
        asm_gen              = '0;
      end
    end
    r.drop_count           = drop_tally;
    r.fragment_error_count = error_tally;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    if (rst) begin
      assembling = 1'b0;
      abandon_message();
      limit_reg   = PAYLOAD_LIMIT;
      free_pool   = '1;
      drop_tally  = '0;
      error_tally = '0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        got.status               = status_t'(status);
        got.buffer_index         = buffer_index;
        got.write_offset         = write_offset;
        got.message_length       = message_length;
        got.message_generation   = message_generation;
        got.message_is_binary    = message_is_binary;
        got.drop_count           = drop_count;
        got.fragment_error_count = fragment_error_count;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result at %0t: status %0d with no request pending",
                     $time, status);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.buffer_index !== want.buffer_index ||
              got.write_offset !== want.write_offset ||
              got.message_length !== want.message_length ||
              got.message_generation !== want.message_generation ||
              got.message_is_binary !== want.message_is_binary ||
              got.drop_count !== want.drop_count ||
              got.fragment_error_count !== want.fragment_error_count) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch at %0t (expected/actual): status %0d/%0d",
                       $time, want.status, got.status,
                       " buffer %0d/%0d offset %0d/%0d length %0d/%0d",
                       want.buffer_index, got.buffer_index, want.write_offset,
                       got.write_offset, want.message_length, got.message_length);
              $display("  generation %h/%h binary %0d/%0d drops %0d/%0d errors %0d/%0d",
                       want.message_generation, got.message_generation,
                       want.message_is_binary, got.message_is_binary,
                       want.drop_count, got.drop_count,
                       want.fragment_error_count, got.fragment_error_count);
            end
          end
        end
      end
      if (cfg_write_en) limit_reg = cfg_write_data;
      if (in_valid && in_ready)
        expected_results.push_back(track_request(op, frame_opcode, total_length,
                                                 fragment_offset, chunk_length,
                                                 conn_generation, release_index));
    end
    outstanding    <= expected_results.size();
    mismatch_count <= mismatches;
  end

endmodule

// ===== dv/websocket_fragment_reassembly_tracker_top_tb.sv =====
// Testbench top for the WebSocket fragment reassembly tracker: clock, reset,
// request stimulus, result consumer and verdict; depends on wfrt_pkg, the
// tracker top level and websocket_fragment_reassembly_tracker_checker.
module websocket_fragment_reassembly_tracker_top_tb;
  import wfrt_pkg::*;

  // This bound only catches hangs; a normal run ends well before it.
  localparam int CYCLE_LIMIT     = 200000;
  // Length of the one long consumer stall that backs the tracker up.
  localparam int HOLD_OFF_CYCLES = 64;
  // Minimum number of requests in each of the four random phases.
  localparam int PHASE_REQUESTS  = 275;

  logic               clk;
  logic               rst;
  logic               cfg_write_en;
  logic [LEN_W-1:0]   cfg_write_data;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         op;
  logic [7:0]         frame_opcode;
  logic [FIELD_W-1:0] total_length;
  logic [FIELD_W-1:0] fragment_offset;
  logic [FIELD_W-1:0] chunk_length;
  logic [GEN_W-1:0]   conn_generation;
  logic [BUF_W-1:0]   release_index;
  logic               out_valid;
  logic               out_ready;
  logic [3:0]         status;
  logic [BUF_W-1:0]   buffer_index;
  logic [OFS_W-1:0]   write_offset;
  logic [LEN_W-1:0]   message_length;
  logic [GEN_W-1:0]   message_generation;
  logic               message_is_binary;
  logic [CNT_W-1:0]   drop_count;
  logic [CNT_W-1:0]   fragment_error_count;

  // Filled in by the checker: failures seen so far and results still owed.
  int mismatch_count;
  int outstanding;

  // While steady is set neither side idles. hold_off_go asks the consumer
  // process for its one long stall. limit_now mirrors the limit register so
  // that message sizes can follow it.
  logic             steady      = 1'b0;
  logic             hold_off_go = 1'b0;
  logic [LEN_W-1:0] limit_now   = PAYLOAD_LIMIT;
  int unsigned      requests_sent = 0;

  websocket_fragment_reassembly_tracker_top i_dut (.*);

  websocket_fragment_reassembly_tracker_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Builds a fragment descriptor. The release index means nothing here, so
  // it is left random.
  function automatic item_t fragment(input logic [7:0] opc, input int unsigned tot, ofs, chk,
                                     input logic [GEN_W-1:0] gen);
    item_t rq;
    rq.op              = OP_FRAGMENT;
    rq.frame_opcode    = opc;
    rq.total_length    = tot[FIELD_W-1:0];
    rq.fragment_offset = ofs[FIELD_W-1:0];
    rq.chunk_length    = chk[FIELD_W-1:0];
    rq.conn_generation = gen;
    rq.release_index   = BUF_W'($urandom_range(1));
    return rq;
  endfunction

  // Builds a release, reset or unknown request. The fragment fields carry
  // random junk, which the tracker must not look at for these operations.
  function automatic item_t control_request(input logic [1:0] kind, input logic [BUF_W-1:0] rel);
    item_t rq;
    rq.op              = kind;
    rq.frame_opcode    = $urandom;
    rq.total_length    = $urandom;
    rq.fragment_offset = $urandom;
    rq.chunk_length    = $urandom;
    rq.conn_generation = $urandom;
    rq.release_index   = rel;
    return rq;
  endfunction

  // Offers one request and returns at the edge where it is accepted. Valid
  // stays high afterwards, so back-to-back requests need no extra cycle; the
  // next call either drops it for an idle cycle or puts new fields on it.
  task automatic offer(input item_t rq);
    while (!steady && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    op              <= rq.op;
    frame_opcode    <= rq.frame_opcode;
    total_length    <= rq.total_length;
    fragment_offset <= rq.fragment_offset;
    chunk_length    <= rq.chunk_length;
    conn_generation <= rq.conn_generation;
    release_index   <= rq.release_index;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
  endtask

  // The limit may only change with nothing in flight, so the sender waits
  // for every result first. The checker publishes its count through a register,
  // which is why the loop always waits for a clock edge before looking.
  task automatic set_limit(input logic [LEN_W-1:0] value);
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (2) @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    limit_now = value;
  endtask

  // A close, ping or pong frame with sane lengths, which the tracker should
  // pass over without touching the message in progress, unless it exceeds the limit.
  task automatic offer_control_frame();
    logic [3:0]  hi;
    logic [3:0]  kind;
    int unsigned tot;
    hi   = $urandom_range(15);
    tot  = $urandom_range(1, 125);
    case ($urandom_range(2))
      0:       kind = OPC_CLOSE;
      1:       kind = OPC_PING;
      default: kind = OPC_PONG;
    endcase
    offer(fragment({hi, kind}, tot, 0, tot, $urandom));
  endtask

  // Sends one text or binary message split into up to four in-order pieces.
  // About one message in eight has a flaw in its last piece: the piece is
  // missing, claims the wrong total, sits at the wrong offset, or carries the
  // opposite data opcode. Control frames now and then land between pieces.
  task automatic send_message();
    int unsigned total, pieces, at, len, k, flaw, cap, tot_used, ofs_used;
    logic [3:0]  kind;
    logic [3:0]  hi;
    logic [7:0]  opc;
    cap    = (limit_now > PAYLOAD_LIMIT) ? PAYLOAD_LIMIT : limit_now;
    total  = ($urandom_range(99) < 85) ? $urandom_range(1, 200) : $urandom_range(1, cap);
    pieces = $urandom_range(1, 4);
    if (pieces > total) pieces = total;
    kind   = $urandom_range(1) ? OPC_BINARY : OPC_TEXT;
    flaw   = ($urandom_range(99) < 12) ? $urandom_range(1, 4) : 0;
    at     = 0;
    for (k = 0; k < pieces; k++) begin
      len = (k == pieces - 1) ? total - at : $urandom_range(1, total - at - (pieces - 1 - k));
      hi  = $urandom_range(15);
      if (k == 0)
        opc = {hi, kind};
      else
        opc = ($urandom_range(3) == 0) ? {hi, kind} : {hi, OPC_CONT};
      tot_used = total;
      ofs_used = at;
      if (k == pieces - 1) begin
        case (flaw)
          2: tot_used = total + 1;
          3: ofs_used = at + 1;
          4: opc = {hi, (kind == OPC_TEXT) ? OPC_BINARY : OPC_TEXT};
          default: ;
        endcase
      end
      if (!(flaw == 1 && k == pieces - 1))
        offer(fragment(opc, tot_used, ofs_used, len, $urandom));
      if ($urandom_range(19) == 0) offer_control_frame();
      at += len;
    end
  endtask

  // Consumer side. It stalls at random, about eight times in a hundred, never
  // while the steady phase runs, and once makes one long stall that it counts itself
  // while the sender keeps offering, so the tracker fills up and drops
  // in_ready.
  initial begin : consumer
    int held;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_go && !rst) begin
        hold_off_go = 1'b0;
        for (held = 0; held < HOLD_OFF_CYCLES; held++) begin
          out_ready <= 1'b0;
          @(posedge clk);
        end
      end
      out_ready <= steady || ($urandom_range(99) >= 8);
      @(posedge clk);
    end
  end

  // A hung handshake ends the run here.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL websocket_fragment_reassembly_tracker_top");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase, phase_end, pick;
    rst             <= 1'b1;
    cfg_write_en    <= 1'b0;
    cfg_write_data  <= '0;
    in_valid        <= 1'b0;
    op              <= OP_FRAGMENT;
    frame_opcode    <= '0;
    total_length    <= '0;
    fragment_offset <= '0;
    chunk_length    <= '0;
    conn_generation <= '0;
    release_index   <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero total or zero chunk length is ignored outright.
    offer(fragment({4'h8, OPC_TEXT}, 0, 0, 5, '0));
    offer(fragment({4'h8, OPC_TEXT}, 5, 0, 0, '0));
    // A two-piece text message lands in buffer 0 and completes; the
    // continuation carries high opcode bits that must be masked off.
    offer(fragment({4'h0, OPC_TEXT}, 100, 0, 40, '1));
    offer(fragment({4'hF, OPC_CONT}, 100, 40, 60, '0));
    // The largest message in a single fragment fills buffer 1.
    offer(fragment({4'h8, OPC_BINARY}, 65536, 0, 65536, '0));
    // Both buffers are still held, so the next message is dropped and its
    // continuation is discarded; control frames are passed over meanwhile.
    offer(fragment({4'h0, OPC_BINARY}, 10, 0, 4, 32'd1));
    offer(fragment({4'h0, OPC_CONT}, 10, 4, 2, 32'd2));
    offer(fragment({4'h8, OPC_CLOSE}, 10, 4, 2, 32'd3));
    offer(fragment({4'h8, OPC_PING}, 10, 0, 10, 32'd3));
    offer(fragment({4'h8, OPC_PONG}, 10, 0, 10, 32'd3));
    offer(control_request(OP_RELEASE, 1'b0));
    offer(control_request(OP_RELEASE, 1'b1));
    // Releasing the buffer under assembly is refused; an unsupported opcode
    // then aborts the assembly and frees the buffer.
    offer(fragment({4'h0, OPC_TEXT}, 50, 0, 10, 32'd7));
    offer(control_request(OP_RELEASE, 1'b0));
    offer(fragment({4'h0, 4'h3}, 50, 10, 10, 32'd8));
    // A continuation with nothing assembling, then one at offset zero.
    offer(fragment({4'h0, OPC_CONT}, 50, 10, 10, 32'd9));
    offer(fragment({4'h0, OPC_CONT}, 50, 0, 10, 32'd9));
    // A binary piece inside a text message does not match.
    offer(fragment({4'h0, OPC_TEXT}, 50, 0, 10, 32'd10));
    offer(fragment({4'h0, OPC_BINARY}, 50, 10, 10, 32'd11));
    // A binary piece inside a binary message does match and completes it.
    offer(fragment({4'h0, OPC_BINARY}, 30, 0, 10, 32'd12));
    offer(fragment({4'h0, OPC_BINARY}, 30, 10, 20, 32'd13));
    // Out of bounds: total above the limit, every field at its maximum,
    // and a chunk running past the total.
    offer(fragment({4'h0, OPC_TEXT}, 65537, 0, 1, '0));
    offer(fragment(8'hFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, '1));
    offer(fragment({4'h0, OPC_TEXT}, 100, 50, 51, '0));
    // A reset request aborts the message just started; op 3 is ignored.
    offer(fragment({4'h0, OPC_TEXT}, 40, 0, 8, 32'd14));
    offer(control_request(OP_RESET, 1'b0));
    offer(control_request(2'd3, 1'b1));
    // Smallest limit: one byte passes, two bytes do not.
    set_limit(17'd1);
    offer(fragment({4'h0, OPC_TEXT}, 1, 0, 1, 32'd15));
    offer(fragment({4'h0, OPC_TEXT}, 2, 0, 1, 32'd16));
    offer(control_request(OP_RELEASE, 1'b0));
    offer(control_request(OP_RELEASE, 1'b1));
    // A zero limit rejects everything.
    set_limit(17'd0);
    offer(fragment({4'h0, OPC_BINARY}, 1, 0, 1, 32'd17));
    // A limit above 64 KiB is clamped back to 64 KiB.
    set_limit(17'h1FFFF);
    offer(fragment({4'h0, OPC_BINARY}, 65537, 0, 1, 32'd18));
    offer(fragment({4'h0, OPC_BINARY}, 65536, 0, 1, 32'd19));
    offer(control_request(OP_RESET, 1'b0));

    // Random phases under different limits. Most traffic is well-formed
    // messages with random content; the rest is releases, resets, control
    // frames and noise. The first phase carries the long consumer stall and
    // the second runs with no idling on either side.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       set_limit(PAYLOAD_LIMIT);
        1:       set_limit(17'd1000);
        2:       set_limit(LEN_W'($urandom_range(1, 65536)));
        default: set_limit(17'h1FFFF);
      endcase
      steady      = (phase == 1);
      hold_off_go = (phase == 0);
      phase_end   = requests_sent + PHASE_REQUESTS;
      while (requests_sent < phase_end) begin
        pick = $urandom_range(99);
        if (pick < 70)
          send_message();
        else if (pick < 84)
          offer(control_request(OP_RELEASE, BUF_W'($urandom_range(1))));
        else if (pick < 88)
          offer(control_request(OP_RESET, BUF_W'($urandom_range(1))));
        else if (pick < 92)
          offer(control_request(2'($urandom_range(3)), BUF_W'($urandom_range(1))));
        else if (pick < 96)
          offer(fragment($urandom, $urandom_range(1, 200), $urandom_range(200),
                         $urandom_range(1, 200), $urandom));
        else
          offer_control_frame();
      end
    end
    steady = 1'b0;

    // Drain: wait for every owed result, then wait on in case anything
    // stray comes out behind them.
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0)
      $display("PASS websocket_fragment_reassembly_tracker_top");
    else
      $display("FAIL websocket_fragment_reassembly_tracker_top");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/wfrt_pkg.sv
design/wfrt_step.sv
design/websocket_fragment_reassembly_tracker_top.sv
dv/websocket_fragment_reassembly_tracker_checker.sv
dv/websocket_fragment_reassembly_tracker_top_tb.sv
